// ===== design/cfm_pkg.sv =====
// cfm_pkg: shared types and constants of the coulomb fit matrix engine
// no dependencies; imported by cfm_mac, coulomb_fit_matrix_engine and the testbench

package cfm_pkg;

	// operation codes of an input item
	typedef enum logic [1:0] {
		OP_LOAD_DENS  = 2'd0,
		OP_LOAD_INT   = 2'd1,
		OP_COEF       = 2'd2,
		OP_COULOMB    = 2'd3
	} op_t;

	// configuration register indexes
	localparam logic [1:0] CFG_NUM_SETS     = 2'd0;
	localparam logic [1:0] CFG_NUM_AUX      = 2'd1;
	localparam logic [1:0] CFG_NUM_PAIRS    = 2'd2;
	localparam logic [1:0] CFG_VJ_OVERWRITE = 2'd3;

	// result kinds
	localparam logic KIND_COEF    = 1'b0;
	localparam logic KIND_COULOMB = 1'b1;

	// widths fixed by the register and field definitions
	localparam int CFG_IW = 2;
	localparam int CFG_DW = 9;
	localparam int CNT_W  = 9;
	localparam int CMP_W  = 9;
	localparam int DATA_W = 32;
	localparam int ACC_W  = 64;

	// half an lsb of q16.16 for rounding a q32.32 product
	localparam logic signed [ACC_W-1:0] ROUND_HALF = 64'sd32768;

	// control into the multiply-accumulate unit
	typedef struct packed {
		logic clear;
		logic in_valid;
		logic add_prior;
	} mac_ctrl_t;

	// status out of the multiply-accumulate unit
	typedef struct packed {
		logic busy;
	} mac_stat_t;

endpackage

// ===== design/cfm_mac.sv =====
// cfm_mac: shared multiply, round and accumulate unit with final saturation
// depends on cfm_pkg

module cfm_mac import cfm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mac_ctrl_t                ctrl,
	input  logic signed [DATA_W-1:0] a,
	input  logic signed [DATA_W-1:0] b,
	input  logic signed [DATA_W-1:0] prior,
	output mac_stat_t                stat,
	output logic signed [DATA_W-1:0] sum_value,
	output logic                     sum_sat
);

	logic                    v_s2;
	logic                    v_s3;
	logic signed [ACC_W-1:0] prod_s2;
	logic signed [ACC_W-1:0] rnd_s3;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] total;

	localparam logic signed [ACC_W-1:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [ACC_W-1:0] SAT_MIN = -64'sh0000_0000_8000_0000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s2 <= ctrl.in_valid;
			v_s3 <= v_s2;
		end
	end

	// product, then round to q16.16 (ties upward), then accumulate
	always_ff @(posedge clk) begin
		prod_s2 <= ACC_W'(a) * ACC_W'(b);
		rnd_s3  <= (prod_s2 + ROUND_HALF) >>> 16;
		if (ctrl.clear) begin
			acc_q <= '0;
		end else if (v_s3) begin
			acc_q <= acc_q + rnd_s3;
		end
	end

	assign total = ctrl.add_prior ? (acc_q + ACC_W'(prior)) : acc_q;

	always_comb begin
		sum_sat   = 1'b1;
		sum_value = DATA_W'(total);
		priority if (total > SAT_MAX) begin
			sum_value = DATA_W'(SAT_MAX);
		end else if (total < SAT_MIN) begin
			sum_value = DATA_W'(SAT_MIN);
		end else begin
			sum_sat = 1'b0;
		end
	end

	assign stat.busy = v_s2 | v_s3;

endmodule

// ===== design/cfm_stores.sv =====
// cfm_stores: density, integral and coefficient memories with registered reads
// no package dependencies

module cfm_stores #(
	parameter int MAX_SETS  = 4,
	parameter int MAX_AUX   = 64,
	parameter int MAX_PAIRS = 256,
	parameter int A_AW      = 10,
	parameter int INT_AW    = 14
) (
	input  logic                 clk,
	input  logic                 dens_we,
	input  logic                 int_we,
	input  logic [31:0]          load_data,
	input  logic [A_AW-1:0]      load_addr_a,
	input  logic [INT_AW-1:0]    load_addr_int,
	input  logic                 coef_we,
	input  logic [A_AW-1:0]      coef_waddr,
	input  logic [31:0]          coef_wdata,
	input  logic                 rd_en,
	input  logic                 a_from_coef,
	input  logic [A_AW-1:0]      a_raddr,
	input  logic [INT_AW-1:0]    b_raddr,
	output logic signed [31:0]   a_data,
	output logic signed [31:0]   b_data
);

	localparam int DENS_DEPTH = MAX_SETS * MAX_PAIRS;
	localparam int INT_DEPTH  = MAX_AUX * MAX_PAIRS;
	localparam int COEF_DEPTH = MAX_SETS * MAX_AUX;
	localparam int DENS_AW    = (DENS_DEPTH > 1) ? $clog2(DENS_DEPTH) : 1;
	localparam int COEF_AW    = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;

	logic [31:0] dens_mem [DENS_DEPTH];
	logic [31:0] int_mem  [INT_DEPTH];
	logic [31:0] coef_mem [COEF_DEPTH];
	logic [31:0] dens_rd_q;
	logic [31:0] coef_rd_q;
	logic [31:0] int_rd_q;

	always_ff @(posedge clk) begin
		if (dens_we) begin
			dens_mem[load_addr_a[DENS_AW-1:0]] <= load_data;
		end
		if (rd_en && !a_from_coef) begin
			dens_rd_q <= dens_mem[a_raddr[DENS_AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (coef_we) begin
			coef_mem[coef_waddr[COEF_AW-1:0]] <= coef_wdata;
		end
		if (rd_en && a_from_coef) begin
			coef_rd_q <= coef_mem[a_raddr[COEF_AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (int_we) begin
			int_mem[load_addr_int] <= load_data;
		end
		if (rd_en) begin
			int_rd_q <= int_mem[b_raddr];
		end
	end

	// the source of operand a stays fixed for the whole item
	assign a_data = a_from_coef ? coef_rd_q : dens_rd_q;
	assign b_data = int_rd_q;

endmodule

// ===== design/coulomb_fit_matrix_engine.sv =====
// coulomb_fit_matrix_engine: top level, sequencer and configuration registers
// depends on cfm_pkg, cfm_stores and cfm_mac
//
// usage
// - command channel: an item is taken on a rising edge with start high and busy low.
//   op 0 / op 1 load one density / integral element in that same cycle; busy stays low.
//   op 2 builds one fitted coefficient (density row dot integral row over num_pairs),
//   stores it and returns it; op 3 builds one coulomb element over num_aux, optionally
//   adding the prior value carried in value, and returns it without storing it
// - an item whose set, aux or pair index is out of range is dropped without a result
// - result channel: result_valid is high for exactly one cycle with result_value,
//   result_kind and saturated; the receiver cannot hold it off, so nothing stalls here
// - a compute runs n operand reads, drains the read register and the mac, then saturates
//   and strobes the result, n being the clamped pair count (op 2) or aux count (op 3);
//   one operand pair a cycle goes through the shared multiply-round-accumulate unit; no new
//   item is taken until the result is out; an empty sum skips the sweep; busy high meanwhile
// - configuration channel: cfg_ready is always high; a transfer writes register
//   cfg_index (0 num_sets, 1 num_aux, 2 num_pairs, 3 vj_overwrite); write only while idle
// - reset: registers return to num_sets 1, num_aux 64, num_pairs 256, vj_overwrite 1;
//   the stores keep whatever they held and must be loaded before use

module coulomb_fit_matrix_engine import cfm_pkg::*; #(
	parameter int MAX_SETS  = 4,
	parameter int MAX_AUX   = 64,
	parameter int MAX_PAIRS = 256
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               op,
	input  logic [5:0]               row_index,
	input  logic [7:0]               column_index,
	input  logic signed [DATA_W-1:0] value,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IW-1:0]        cfg_index,
	input  logic [CFG_DW-1:0]        cfg_data,
	output logic                     result_valid,
	output logic signed [DATA_W-1:0] result_value,
	output logic                     result_kind,
	output logic                     saturated
);

	localparam int DENS_DEPTH = MAX_SETS * MAX_PAIRS;
	localparam int INT_DEPTH  = MAX_AUX * MAX_PAIRS;
	localparam int COEF_DEPTH = MAX_SETS * MAX_AUX;
	localparam int DENS_AW    = (DENS_DEPTH > 1) ? $clog2(DENS_DEPTH) : 1;
	localparam int COEF_AW    = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
	localparam int INT_AW     = (INT_DEPTH > 1) ? $clog2(INT_DEPTH) : 1;
	localparam int A_AW       = (DENS_AW > COEF_AW) ? DENS_AW : COEF_AW;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// configuration registers
	logic [2:0] num_sets_q;
	logic [6:0] num_aux_q;
	logic [8:0] num_pairs_q;
	logic       vj_overwrite_q;

	// counts clamped to the store sizes
	logic [2:0] ns;
	logic [6:0] na;
	logic [8:0] np;

	// sequencer and datapath registers
	state_t                   state_q;
	logic                     kind_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [A_AW-1:0]          a_addr_q;
	logic [INT_AW-1:0]        b_addr_q;
	logic [A_AW-1:0]          cw_addr_q;
	logic signed [DATA_W-1:0] prior_q;
	logic                     add_prior_q;
	logic                     clear_q;
	logic                     rd_v_s1;
	logic                     result_valid_q;
	logic signed [DATA_W-1:0] result_value_q;
	logic                     result_kind_q;
	logic                     saturated_q;

	// decode of the offered item
	op_t              op_in;
	logic             accept;
	logic             row_lt_ns;
	logic             row_lt_na;
	logic             col_lt_na;
	logic             col_lt_np;
	logic             item_ok;
	logic             is_compute;
	logic [CNT_W-1:0] n_len;
	logic [A_AW-1:0]  load_addr_a;
	logic [INT_AW-1:0] load_addr_int;
	logic [A_AW-1:0]  a_start;
	logic [INT_AW-1:0] b_start;
	logic [A_AW-1:0]  cw_addr;
	logic [INT_AW-1:0] b_step;
	logic             rd_en;
	logic             dens_we;
	logic             int_we;
	logic             coef_we;

	logic signed [DATA_W-1:0] a_data;
	logic signed [DATA_W-1:0] b_data;
	mac_ctrl_t                mac_ctrl;
	mac_stat_t                mac_stat;
	logic signed [DATA_W-1:0] sum_value;
	logic                     sum_sat;

	// configuration port, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_sets_q     <= 3'd1;
			num_aux_q      <= 7'd64;
			num_pairs_q    <= 9'd256;
			vj_overwrite_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_NUM_SETS:     num_sets_q     <= cfg_data[2:0];
				CFG_NUM_AUX:      num_aux_q      <= cfg_data[6:0];
				CFG_NUM_PAIRS:    num_pairs_q    <= cfg_data[8:0];
				CFG_VJ_OVERWRITE: vj_overwrite_q <= cfg_data[0];
				default:          ;
			endcase
		end
	end

	// clamp the counts to what the stores hold
	assign ns = (32'(num_sets_q) > 32'(MAX_SETS)) ? 3'(MAX_SETS) : num_sets_q;
	assign na = (32'(num_aux_q) > 32'(MAX_AUX)) ? 7'(MAX_AUX) : num_aux_q;
	assign np = (32'(num_pairs_q) > 32'(MAX_PAIRS)) ? 9'(MAX_PAIRS) : num_pairs_q;

	assign op_in     = op_t'(op);
	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;

	assign row_lt_ns = CMP_W'(row_index) < CMP_W'(ns);
	assign row_lt_na = CMP_W'(row_index) < CMP_W'(na);
	assign col_lt_na = CMP_W'(column_index) < CMP_W'(na);
	assign col_lt_np = CMP_W'(column_index) < CMP_W'(np);

	// address of an element as row times row length plus column
	assign load_addr_a   = A_AW'(32'(row_index) * MAX_PAIRS + 32'(column_index));
	assign load_addr_int = INT_AW'(32'(row_index) * MAX_PAIRS + 32'(column_index));
	assign cw_addr       = A_AW'(32'(row_index) * MAX_AUX + 32'(column_index));

	always_comb begin
		item_ok    = 1'b0;
		is_compute = 1'b0;
		n_len      = np;
		a_start    = A_AW'(32'(row_index) * MAX_PAIRS);
		b_start    = INT_AW'(32'(column_index) * MAX_PAIRS);
		unique case (op_in)
			OP_LOAD_DENS: begin
				item_ok = row_lt_ns && col_lt_np;
			end
			OP_LOAD_INT: begin
				item_ok = row_lt_na && col_lt_np;
			end
			OP_COEF: begin
				item_ok    = row_lt_ns && col_lt_na;
				is_compute = 1'b1;
			end
			OP_COULOMB: begin
				// coefficient row of the set against an integral column
				item_ok    = row_lt_ns && col_lt_np;
				is_compute = 1'b1;
				n_len      = CNT_W'(na);
				a_start    = A_AW'(32'(row_index) * MAX_AUX);
				b_start    = INT_AW'(column_index);
			end
			default: ;
		endcase
	end

	assign dens_we = accept && item_ok && (op_in == OP_LOAD_DENS);
	assign int_we  = accept && item_ok && (op_in == OP_LOAD_INT);
	assign coef_we = (state_q == ST_DONE) && (kind_q == KIND_COEF);

	// coefficient sweep walks along a row, coulomb sweep down a column
	assign b_step = (kind_q == KIND_COULOMB) ? INT_AW'(MAX_PAIRS) : INT_AW'(1);
	assign rd_en  = (state_q == ST_RUN);

	// sequencer: issue one operand read per cycle, drain the mac, then saturate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
			rd_v_s1        <= 1'b0;
			clear_q        <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			clear_q        <= 1'b0;
			rd_v_s1        <= rd_en;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && item_ok && is_compute) begin
						kind_q      <= (op_in == OP_COULOMB) ? KIND_COULOMB : KIND_COEF;
						cnt_q       <= n_len;
						a_addr_q    <= a_start;
						b_addr_q    <= b_start;
						cw_addr_q   <= cw_addr;
						prior_q     <= value;
						add_prior_q <= (op_in == OP_COULOMB) && !vj_overwrite_q;
						clear_q     <= 1'b1;
						// an empty sum goes straight to the drain
						state_q     <= (n_len == '0) ? ST_DRAIN : ST_RUN;
					end
				end
				ST_RUN: begin
					cnt_q    <= cnt_q - CNT_W'(1);
					a_addr_q <= a_addr_q + A_AW'(1);
					b_addr_q <= b_addr_q + b_step;
					if (cnt_q == CNT_W'(1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!rd_v_s1 && !mac_stat.busy && !clear_q) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					result_valid_q <= 1'b1;
					result_value_q <= sum_value;
					result_kind_q  <= kind_q;
					saturated_q    <= sum_sat;
					state_q        <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result_value = result_value_q;
	assign result_kind  = result_kind_q;
	assign saturated    = saturated_q;

	cfm_stores #(
		.MAX_SETS  (MAX_SETS),
		.MAX_AUX   (MAX_AUX),
		.MAX_PAIRS (MAX_PAIRS),
		.A_AW      (A_AW),
		.INT_AW    (INT_AW)
	) u_stores (
		.clk           (clk),
		.dens_we       (dens_we),
		.int_we        (int_we),
		.load_data     (value),
		.load_addr_a   (load_addr_a),
		.load_addr_int (load_addr_int),
		.coef_we       (coef_we),
		.coef_waddr    (cw_addr_q),
		.coef_wdata    (sum_value),
		.rd_en         (rd_en),
		.a_from_coef   (kind_q),
		.a_raddr       (a_addr_q),
		.b_raddr       (b_addr_q),
		.a_data        (a_data),
		.b_data        (b_data)
	);

	assign mac_ctrl.clear     = clear_q;
	assign mac_ctrl.in_valid  = rd_v_s1;
	assign mac_ctrl.add_prior = add_prior_q;

	cfm_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (mac_ctrl),
		.a         (a_data),
		.b         (b_data),
		.prior     (prior_q),
		.stat      (mac_stat),
		.sum_value (sum_value),
		.sum_sat   (sum_sat)
	);

	// a result strobe lasts a single cycle
	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe held for more than one cycle");

	// every result comes out of the finishing step
	a_strobe_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(state_q == ST_DONE))
		else $error("result strobe without a finished compute");

	// a clipped result sits at one of the two limits
	a_sat_limits: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && saturated) |->
		(result_value == 32'sh7FFF_FFFF || result_value == -32'sh8000_0000))
		else $error("saturated result not at a limit");

	// a valid compute item makes the block busy
	a_compute_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item_ok && is_compute) |=> busy)
		else $error("compute item taken without going busy");

	// operand reads only happen while sweeping
	a_no_idle_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !rd_en)
		else $error("operand read issued while idle");

endmodule

// ===== tb/tb_coulomb_fit_matrix_engine.sv =====
`timescale 1ns / 100ps
// tb_coulomb_fit_matrix_engine: self-checking bench for the density-fitting coulomb engine
// drives commands and register writes, predicts every coefficient and coulomb element
// depends on cfm_pkg and coulomb_fit_matrix_engine

module tb_coulomb_fit_matrix_engine;
	import cfm_pkg::*;

	// store sizes of the block as instantiated (default parameters)
	localparam int MAX_SETS    = 4;
	localparam int MAX_AUX     = 64;
	localparam int MAX_PAIRS   = 256;
	// generous bound on the whole run, and on the wait for results still in flight
	localparam int CYCLE_LIMIT = 5000000;
	localparam int DRAIN_LIMIT = 400;

	// one predicted result transfer
	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     kind;
		logic                     clipped;
	} fit_result_t;

	logic                     clk          = 1'b0;
	logic                     arst_n       = 1'b0;
	logic                     start        = 1'b0;
	logic                     busy;
	logic [1:0]               op           = OP_LOAD_DENS;
	logic [5:0]               row_index    = '0;
	logic [7:0]               column_index = '0;
	logic signed [DATA_W-1:0] value        = '0;
	logic                     cfg_valid    = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IW-1:0]        cfg_index    = CFG_NUM_SETS;
	logic [CFG_DW-1:0]        cfg_data     = '0;
	logic                     result_valid;
	logic signed [DATA_W-1:0] result_value;
	logic                     result_kind;
	logic                     saturated;

	// predicted copy of the block: registers at their reset values, stores and written marks
	logic [2:0]               set_count_reg  = 3'd1;
	logic [6:0]               aux_count_reg  = 7'd64;
	logic [8:0]               pair_count_reg = 9'd256;
	logic                     overwrite_reg  = 1'b1;
	logic signed [DATA_W-1:0] density_mem  [MAX_SETS*MAX_PAIRS];
	logic signed [DATA_W-1:0] integral_mem [MAX_AUX*MAX_PAIRS];
	logic signed [DATA_W-1:0] coef_mem     [MAX_SETS*MAX_AUX];
	bit                       density_loaded  [MAX_SETS*MAX_PAIRS];
	bit                       integral_loaded [MAX_AUX*MAX_PAIRS];
	bit                       coef_loaded     [MAX_SETS*MAX_AUX];

	fit_result_t expected_results [$];
	fit_result_t oldest_result;
	int          error_count     = 0;
	int          live_items      = 0;  // accepted items that the block acts upon
	int          sender_idle_pct = 0;
	int unsigned cycle_count     = 0;

	coulomb_fit_matrix_engine i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.op           (op),
		.row_index    (row_index),
		.column_index (column_index),
		.value        (value),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result_value (result_value),
		.result_kind  (result_kind),
		.saturated    (saturated)
	);

	always #5 clk = ~clk;

	// hard stop should the block hang or lose results
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic report_error(input string what);
		$display("%0t ERROR %s", $time, what);
		error_count++;
	endtask

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------

	function automatic int sets_in_use();
		return (set_count_reg > MAX_SETS) ? MAX_SETS : int'(set_count_reg);
	endfunction

	function automatic int aux_in_use();
		return (aux_count_reg > MAX_AUX) ? MAX_AUX : int'(aux_count_reg);
	endfunction

	function automatic int pairs_in_use();
		return (pair_count_reg > MAX_PAIRS) ? MAX_PAIRS : int'(pair_count_reg);
	endfunction

	// exact q32.32 product brought back to q16.16, ties going towards +infinity
	function automatic longint rounded_product(input logic signed [DATA_W-1:0] a,
			input logic signed [DATA_W-1:0] b);
		longint p;
		p = longint'(a) * longint'(b);
		return (p + 64'sd32768) >>> 16;
	endfunction

	// clip the wide sum to 32 bits and flag it
	function automatic fit_result_t clip_sum(input longint total, input logic kind);
		fit_result_t r;
		r.kind = kind;
		r.clipped = 1'b1;
		if (total > 64'sd2147483647)
			r.value = 32'sh7fffffff;
		else if (total < -64'sd2147483648)
			r.value = 32'sh80000000;
		else begin
			r.value = total[31:0];
			r.clipped = 1'b0;
		end
		return r;
	endfunction

	// applies one accepted command to the predicted state, queues its result if any
	function automatic void predict_command(input op_t kind, input int row, input int col,
			input logic signed [DATA_W-1:0] val);
		int          ns;
		int          na;
		int          np;
		int          k;
		longint      total;
		fit_result_t r;
		ns = sets_in_use();
		na = aux_in_use();
		np = pairs_in_use();
		total = 0;
		case (kind)
			OP_LOAD_DENS: begin
				if (row < ns && col < np) begin
					density_mem[row*MAX_PAIRS+col] = val;
					density_loaded[row*MAX_PAIRS+col] = 1'b1;
					live_items++;
				end
			end
			OP_LOAD_INT: begin
				if (row < na && col < np) begin
					integral_mem[row*MAX_PAIRS+col] = val;
					integral_loaded[row*MAX_PAIRS+col] = 1'b1;
					live_items++;
				end
			end
			OP_COEF: begin
				// row is the set, col the aux function; dot product over the pairs
				if (row < ns && col < na) begin
					for (k = 0; k < np; k++)
						total += rounded_product(density_mem[row*MAX_PAIRS+k],
							integral_mem[col*MAX_PAIRS+k]);
					r = clip_sum(total, KIND_COEF);
					coef_mem[row*MAX_AUX+col] = r.value;
					coef_loaded[row*MAX_AUX+col] = 1'b1;
					expected_results.push_back(r);
					live_items++;
				end
			end
			default: begin
				// row is the set, col the pair; sum over the aux functions
				if (row < ns && col < np) begin
					for (k = 0; k < na; k++)
						total += rounded_product(coef_mem[row*MAX_AUX+k],
							integral_mem[k*MAX_PAIRS+col]);
					if (!overwrite_reg)
						total += longint'(val);
					expected_results.push_back(clip_sum(total, KIND_COULOMB));
					live_items++;
				end
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// result checking: the receiver cannot stall, so every strobe is a transfer
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (expected_results.size() == 0)
				report_error($sformatf("result %h kind %b with nothing outstanding",
					result_value, result_kind));
			else begin
				oldest_result = expected_results.pop_front();
				if (result_value !== oldest_result.value)
					report_error($sformatf("result_value got %h want %h",
						result_value, oldest_result.value));
				if (result_kind !== oldest_result.kind)
					report_error($sformatf("result_kind got %b want %b",
						result_kind, oldest_result.kind));
				if (saturated !== oldest_result.clipped)
					report_error($sformatf("saturated got %b want %b (value %h)",
						saturated, oldest_result.clipped, oldest_result.value));
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	// q16.16 operand: mostly modest magnitudes so that sums stay in range,
	// some full-width and corner values so that clipping happens too
	function automatic logic signed [DATA_W-1:0] random_q16();
		logic [31:0] raw;
		int          pick;
		raw = $urandom;
		pick = $urandom_range(99);
		if (pick < 40)
			raw = {{14{raw[17]}}, raw[17:0]};
		else if (pick < 65)
			raw = {{10{raw[21]}}, raw[21:0]};
		else if (pick < 75)
			raw = {{6{raw[25]}}, raw[25:0]};
		else if (pick >= 90) begin
			case ($urandom_range(7))
				0: raw = 32'h00000000;
				1: raw = 32'h00000001;
				2: raw = 32'hffffffff;
				3: raw = 32'h7fffffff;
				4: raw = 32'h80000000;
				5: raw = 32'h00008000;
				6: raw = 32'h00010000;
				default: raw = 32'hffff0000;
			endcase
		end
		return raw;
	endfunction

	// mostly an index in range, sometimes anything the field can carry
	function automatic int pick_index(input int limit, input int field_max);
		if (limit == 0 || $urandom_range(99) < 15)
			return $urandom_range(field_max);
		return $urandom_range(limit - 1);
	endfunction

	// entered and left at a falling edge; start stays high after the transfer,
	// so the caller either sends again or lowers it through drain_results
	task automatic send_command(input op_t kind, input int row, input int col,
			input logic signed [DATA_W-1:0] val);
		int gap;
		gap = 0;
		while ($urandom_range(99) < sender_idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		op <= kind;
		row_index <= row[5:0];
		column_index <= col[7:0];
		value <= val;
		do @(posedge clk); while (busy);
		predict_command(kind, row, col, val);
		@(negedge clk);
	endtask

	// waits for every outstanding result, then lets a compute dropped or still running settle
	task automatic drain_results();
		int guard;
		int settle;
		start <= 1'b0;
		@(negedge clk);
		guard = 0;
		while (expected_results.size() != 0 && guard < DRAIN_LIMIT) begin
			@(negedge clk);
			guard++;
		end
		if (expected_results.size() != 0) begin
			report_error($sformatf("%0d results never arrived", expected_results.size()));
			expected_results.delete();
		end
		settle = (aux_in_use() > pairs_in_use() ? aux_in_use() : pairs_in_use()) + 8;
		repeat (settle) @(negedge clk);
	endtask

	// one register transfer; bits above the register width carry junk to be dropped
	task automatic write_register(input logic [CFG_IW-1:0] idx, input int setting,
			input bit last);
		int                width;
		logic [CFG_DW-1:0] data;
		case (idx)
			CFG_NUM_SETS:  width = 3;
			CFG_NUM_AUX:   width = 7;
			CFG_NUM_PAIRS: width = 9;
			default:       width = 1;
		endcase
		data = CFG_DW'(($urandom << width) | (setting & ((1 << width) - 1)));
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_NUM_SETS:  set_count_reg = data[2:0];
			CFG_NUM_AUX:   aux_count_reg = data[6:0];
			CFG_NUM_PAIRS: pair_count_reg = data[8:0];
			default:       overwrite_reg = data[0];
		endcase
		@(negedge clk);
		if (last)
			cfg_valid <= 1'b0;
	endtask

	task automatic apply_settings(input int sets, input int aux, input int pairs,
			input bit overwrite);
		drain_results();
		write_register(CFG_NUM_SETS, sets, 1'b0);
		write_register(CFG_NUM_AUX, aux, 1'b0);
		write_register(CFG_NUM_PAIRS, pairs, 1'b0);
		write_register(CFG_VJ_OVERWRITE, overwrite, 1'b1);
	endtask

	// load every density and integral element a coefficient would read and that is still blank
	task automatic fill_coef_operands(input int set_idx, input int aux_idx);
		int k;
		if (set_idx < sets_in_use() && aux_idx < aux_in_use()) begin
			for (k = 0; k < pairs_in_use(); k++) begin
				if (!density_loaded[set_idx*MAX_PAIRS+k])
					send_command(OP_LOAD_DENS, set_idx, k, random_q16());
				if (!integral_loaded[aux_idx*MAX_PAIRS+k])
					send_command(OP_LOAD_INT, aux_idx, k, random_q16());
			end
		end
	endtask

	// a coulomb element needs a whole coefficient row; build the missing ones first
	task automatic fill_coulomb_operands(input int set_idx, input int pair_idx);
		int l;
		if (set_idx < sets_in_use() && pair_idx < pairs_in_use()) begin
			for (l = 0; l < aux_in_use(); l++) begin
				if (!integral_loaded[l*MAX_PAIRS+pair_idx])
					send_command(OP_LOAD_INT, l, pair_idx, random_q16());
				if (!coef_loaded[set_idx*MAX_AUX+l]) begin
					fill_coef_operands(set_idx, l);
					send_command(OP_COEF, set_idx, l, random_q16());
				end
			end
		end
	endtask

	task automatic run_compute(input op_t kind, input int row, input int col,
			input logic signed [DATA_W-1:0] val);
		if (kind == OP_COEF)
			fill_coef_operands(row, col);
		else
			fill_coulomb_operands(row, col);
		send_command(kind, row, col, val);
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// registers straight out of reset: one set, 64 aux, 256 pairs, overwrite on
	task automatic test_reset_values();
		send_command(OP_LOAD_DENS, 1, 0, random_q16());   // only set 0 exists
		run_compute(OP_COEF, 0, 63, random_q16());        // full pair count, top aux
		send_command(OP_COEF, 1, 0, random_q16());        // dropped
		drain_results();
		write_register(CFG_NUM_AUX, 1, 1'b1);
		run_compute(OP_COULOMB, 0, 255, 32'sh12345678);   // prior ignored while overwriting
	endtask

	// single-term sums: rounding ties and clipping in both directions
	task automatic test_rounding_and_saturation();
		apply_settings(1, 1, 1, 1'b0);
		send_command(OP_LOAD_DENS, 0, 0, 32'sh00000001);
		send_command(OP_LOAD_INT, 0, 0, 32'sh00008000);
		send_command(OP_COEF, 0, 0, 32'sh0);              // half an lsb rounds up
		send_command(OP_COULOMB, 0, 0, 32'sh7fffffff);    // prior pushes it over the top
		send_command(OP_LOAD_DENS, 0, 0, 32'shffffffff);
		send_command(OP_COEF, 0, 0, 32'sh0);              // minus half an lsb rounds to zero
		send_command(OP_COULOMB, 0, 0, 32'sh80000000);    // most negative prior, no clip
		send_command(OP_LOAD_DENS, 0, 0, 32'sh7fffffff);
		send_command(OP_LOAD_INT, 0, 0, 32'sh7fffffff);
		send_command(OP_COEF, 0, 0, 32'sh0);              // clips high
		send_command(OP_COULOMB, 0, 0, 32'sh0);
		send_command(OP_LOAD_INT, 0, 0, 32'sh80000000);
		send_command(OP_COEF, 0, 0, 32'sh0);              // clips low
		send_command(OP_COULOMB, 0, 0, 32'sh80000000);
		send_command(OP_LOAD_DENS, 0, 0, 32'sh80000000);
		send_command(OP_COEF, 0, 0, 32'sh0);              // two most negative operands
		send_command(OP_LOAD_DENS, 0, 0, 32'sh00010000);
		send_command(OP_LOAD_INT, 0, 0, 32'shffff0000);
		send_command(OP_COEF, 0, 0, 32'sh0);              // 1.0 times -1.0
		apply_settings(1, 1, 1, 1'b1);
		send_command(OP_COULOMB, 0, 0, 32'sh7fffffff);    // prior dropped when overwriting
	endtask

	// zero counts, counts beyond the stores, top indexes
	task automatic test_count_limits();
		apply_settings(0, 3, 3, 1'b1);                    // no set in use at all
		send_command(OP_LOAD_DENS, 0, 0, random_q16());
		send_command(OP_COEF, 0, 0, random_q16());
		send_command(OP_COULOMB, 0, 0, random_q16());
		send_command(OP_LOAD_INT, 2, 2, random_q16());    // integral loads do not need a set
		apply_settings(7, 127, 511, 1'b0);                // clamped to the store sizes
		send_command(OP_LOAD_DENS, 4, 0, random_q16());   // beyond the clamped set count
		send_command(OP_LOAD_DENS, 3, 255, random_q16());
		send_command(OP_LOAD_INT, 63, 255, random_q16());
		run_compute(OP_COEF, 3, 63, random_q16());
		apply_settings(4, 64, 1, 1'b0);
		run_compute(OP_COULOMB, 3, 0, random_q16());      // every aux function of the top set
		apply_settings(2, 0, 4, 1'b0);
		run_compute(OP_COULOMB, 1, 3, 32'sh7fffffff);     // empty sum returns the prior
		send_command(OP_COEF, 1, 0, random_q16());        // no aux function in use
		apply_settings(2, 4, 0, 1'b1);
		run_compute(OP_COEF, 1, 3, random_q16());         // empty sum over pairs
		send_command(OP_COULOMB, 1, 0, random_q16());     // no pair in use
		send_command(OP_LOAD_DENS, 0, 0, random_q16());
	endtask

	// each operation just past its counts and at the field maximum, then at the last valid index
	task automatic test_index_range();
		apply_settings(2, 5, 6, 1'b0);
		send_command(OP_LOAD_DENS, 2, 0, random_q16());
		send_command(OP_LOAD_DENS, 0, 6, random_q16());
		send_command(OP_LOAD_DENS, 63, 255, random_q16());
		send_command(OP_LOAD_INT, 5, 0, random_q16());
		send_command(OP_LOAD_INT, 0, 6, random_q16());
		send_command(OP_LOAD_INT, 63, 255, random_q16());
		send_command(OP_COEF, 2, 0, random_q16());
		send_command(OP_COEF, 0, 5, random_q16());
		send_command(OP_COEF, 63, 255, random_q16());
		send_command(OP_COULOMB, 2, 0, random_q16());
		send_command(OP_COULOMB, 0, 6, random_q16());
		send_command(OP_COULOMB, 63, 255, random_q16());
		run_compute(OP_COEF, 1, 4, random_q16());
		run_compute(OP_COULOMB, 1, 5, random_q16());
	endtask

	// mostly small sizes so that operand sets load quickly; now and then the extremes
	task automatic random_settings();
		int sets;
		int aux;
		int pairs;
		int pick;
		sets = ($urandom_range(99) < 10) ? $urandom_range(7) : $urandom_range(1, 4);
		pick = $urandom_range(99);
		if (pick < 70) begin
			aux = $urandom_range(1, 8);
			pairs = $urandom_range(1, 16);
		end else if (pick < 80) begin
			aux = $urandom_range(9, 32);
			pairs = $urandom_range(1, 32);
		end else if (pick < 88) begin
			case ($urandom_range(2))
				0: aux = 0;
				1: aux = 64;
				default: aux = 127;
			endcase
			pairs = $urandom_range(0, 16);
		end else begin
			aux = $urandom_range(0, 4);
			case ($urandom_range(3))
				0: pairs = 0;
				1: pairs = 256;
				2: pairs = 511;
				default: pairs = $urandom_range(17, 200);
			endcase
		end
		apply_settings(sets, aux, pairs, $urandom_range(1));
	endtask

	// one random command; computes get their operands loaded first
	task automatic random_command();
		int ns;
		int na;
		int np;
		int pick;
		ns = sets_in_use();
		na = aux_in_use();
		np = pairs_in_use();
		pick = $urandom_range(99);
		if (pick < 15)
			send_command(OP_LOAD_DENS, pick_index(ns, 63), pick_index(np, 255), random_q16());
		else if (pick < 30)
			send_command(OP_LOAD_INT, pick_index(na, 63), pick_index(np, 255), random_q16());
		else if (pick < 65)
			run_compute(OP_COEF, pick_index(ns, 63), pick_index(na, 255), random_q16());
		else
			run_compute(OP_COULOMB, pick_index(ns, 63), pick_index(np, 255), random_q16());
	endtask

	task automatic test_random_traffic(input int idle_pct, input int quota);
		int goal;
		int batch;
		sender_idle_pct = idle_pct;
		goal = live_items + quota;
		while (live_items < goal) begin
			random_settings();
			batch = $urandom_range(25, 50);
			while (batch > 0 && live_items < goal) begin
				random_command();
				batch--;
			end
		end
	endtask

	initial begin
		// reset held low from the start, released on a falling edge
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_values();
		test_rounding_and_saturation();
		test_count_limits();
		test_index_range();
		// sender always ready, then mostly idle, then idle now and again
		test_random_traffic(0, 240);
		test_random_traffic(74, 230);
		test_random_traffic(27, 230);

		drain_results();
		if (error_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== files.f =====
design/cfm_pkg.sv
design/cfm_mac.sv
design/cfm_stores.sv
design/coulomb_fit_matrix_engine.sv
tb/tb_coulomb_fit_matrix_engine.sv
